### design/lmf_pkg.sv
package lmf_pkg;

	localparam int MAX_RADIUS     = 15;
	localparam int SAMPLE_W       = 32;
	localparam int HW_CFG_W       = 4;
	localparam int LINE_POS_W     = 6;
	localparam logic [LINE_POS_W-1:0] POS_MAX = '1;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample_in;
		logic                       line_end_in;
	} lmf_in_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample_out;
		logic                       was_filtered;
		logic                       line_end_out;
	} lmf_out_t;

	// control shared by every cell of the row
	typedef struct packed {
		logic shift;
		logic count;
	} lmf_ctl_t;

endpackage

### design/lmf_cell.sv
module lmf_cell
	import lmf_pkg::*;
#(
	parameter int HW_W  = 4,
	parameter int CNT_W = 5
) (
	input  logic                       clk,
	input  lmf_ctl_t                   ctl,
	input  logic                       active,
	input  logic [HW_W-1:0]            h,
	input  logic signed [SAMPLE_W-1:0] win_in,
	input  logic signed [SAMPLE_W-1:0] circ_in,
	output logic signed [SAMPLE_W-1:0] win,
	output logic signed [SAMPLE_W-1:0] circ,
	output logic                       hit
);

	logic signed [SAMPLE_W-1:0] win_q;
	logic signed [SAMPLE_W-1:0] circ_q;
	logic [CNT_W-1:0]           less_q;
	logic [CNT_W-1:0]           equal_q;
	logic [CNT_W:0]             upper;
	logic [CNT_W:0]             h_ext;

	// own sample stays put, the circulating copy walks past it once per window
	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			win_q   <= win_in;
			circ_q  <= win_in;
			less_q  <= '0;
			equal_q <= '0;
		end else if (ctl.count) begin
			circ_q <= circ_in;
			if (active) begin
				if (circ_q < win_q)
					less_q <= less_q + CNT_W'(1);
				else if (circ_q == win_q)
					equal_q <= equal_q + CNT_W'(1);
			end
		end
	end

	assign upper = {1'b0, less_q} + {1'b0, equal_q};
	assign h_ext = (CNT_W+1)'(h);
	assign hit   = active && ({1'b0, less_q} <= h_ext) && (h_ext < upper);
	assign win   = win_q;
	assign circ  = circ_q;

endmodule

### design/line_median_filter.sv
// channel   | direction | beat payload | handshake
// in        | input     | lmf_in_t     | in_valid / in_stall
// out       | output    | lmf_out_t    | out_valid / out_stall
// cfg       | input     | radius       | cfg_we, no wait
//
// a sample that completes no window median is accepted and then its results, if any, are handed out
// a sample that completes a window is ranked first, then its median is picked, then its results handed out:
// the circulating copies walk once around the 2*h+1 active cells of the row to rank every sample
// reset clears control, position and half width; window contents need no clearing
// in_stall is high while a sample is being ranked or its results handed out
// out_stall holds the output register; the row waits, nothing is dropped
module line_median_filter
	import lmf_pkg::*;
#(
	parameter int MAX_HW = MAX_RADIUS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [HW_CFG_W-1:0] cfg_wdata,
	input  logic                in_valid,
	output logic                in_stall,
	input  lmf_in_t             in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output lmf_out_t            out_data
);

	localparam int DEPTH = 2 * MAX_HW + 1;
	localparam int HW_W  = $clog2(MAX_HW + 1);
	localparam int IW    = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CW    = LINE_POS_W + 1;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_COUNT = 2'd1;
	localparam logic [1:0] ST_PICK  = 2'd2;
	localparam logic [1:0] ST_EMIT  = 2'd3;

	logic [1:0]                 state_q;
	logic [HW_CFG_W-1:0]        cfg_hw_q;
	logic [LINE_POS_W-1:0]      pos_q;
	logic [HW_W-1:0]            h_q;
	logic [IW-1:0]              cnt_q;
	logic [IW-1:0]              idx_q;
	logic                       first_q;
	logic                       filt_q;
	logic                       tail_q;
	logic signed [SAMPLE_W-1:0] med_q;
	logic                       out_valid_q;
	lmf_out_t                   out_q;

	logic                       accept;
	logic [HW_W-1:0]            h_cfg;
	logic [HW_W-1:0]            h_eff;
	logic [CW-1:0]              p_ext;
	logic [CW-1:0]              h_ext;
	logic [CW-1:0]              h2_ext;
	logic                       has_first;
	logic                       has_median;
	logic [HW_W:0]              h2;
	logic                       count_done;
	logic                       out_free;
	logic                       load;
	logic [IW-1:0]              rd_idx;
	logic signed [SAMPLE_W-1:0] rd_data;
	logic signed [SAMPLE_W-1:0] med_or;
	lmf_ctl_t                   ctl;

	logic signed [SAMPLE_W-1:0] win  [DEPTH];
	logic signed [SAMPLE_W-1:0] circ [DEPTH];
	logic                       hit  [DEPTH];

	assign accept   = (state_q == ST_IDLE) && in_valid;
	assign in_stall = (state_q != ST_IDLE);

	// out of range half widths clamp to the nearest legal value
	always_comb begin
		if (cfg_hw_q == '0)
			h_cfg = HW_W'(1);
		else if (32'(cfg_hw_q) > 32'(MAX_HW))
			h_cfg = HW_W'(MAX_HW);
		else
			h_cfg = HW_W'(cfg_hw_q);
	end

	assign h_eff      = (pos_q == '0) ? h_cfg : h_q;
	assign p_ext      = CW'(pos_q);
	assign h_ext      = CW'(h_eff);
	assign h2_ext     = CW'({h_eff, 1'b0});
	assign has_first  = (p_ext >= h_ext);
	assign has_median = (p_ext >= h2_ext);

	assign h2         = {h_q, 1'b0};
	assign count_done = ((IW+1)'(cnt_q) == (IW+1)'(h2));

	assign ctl.shift = accept;
	assign ctl.count = (state_q == ST_COUNT);

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [SAMPLE_W-1:0] win_in;
		logic signed [SAMPLE_W-1:0] circ_in;
		logic                       active;

		if (i == 0) begin : g_head
			assign win_in = in_data.sample_in;
		end else begin : g_body
			assign win_in = win[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign circ_in = circ[0];
		end else begin : g_ring
			assign circ_in = ((HW_W+1)'(i) == h2) ? circ[0] : circ[i+1];
		end

		assign active = ((HW_W+1)'(i) <= h2);

		lmf_cell #(
			.HW_W  (HW_W),
			.CNT_W (CNT_W)
		) u_cell (
			.clk     (clk),
			.ctl     (ctl),
			.active  (active),
			.h       (h_q),
			.win_in  (win_in),
			.circ_in (circ_in),
			.win     (win[i]),
			.circ    (circ[i]),
			.hit     (hit[i])
		);
	end

	// every cell that hits holds the median value, so an or of the hits is enough
	always_comb begin
		med_or = '0;
		for (int i = 0; i < DEPTH; i++)
			med_or = med_or | (hit[i] ? win[i] : '0);
	end

	assign rd_idx  = first_q ? IW'(h_q) : idx_q;
	assign rd_data = win[rd_idx];

	assign out_free = !out_valid_q || !out_stall;
	assign load     = (state_q == ST_EMIT) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_hw_q <= HW_CFG_W'(1);
		end else if (cfg_we) begin
			cfg_hw_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pos_q   <= '0;
			h_q     <= HW_W'(1);
			cnt_q   <= '0;
			idx_q   <= '0;
			first_q <= 1'b0;
			filt_q  <= 1'b0;
			tail_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						h_q     <= h_eff;
						cnt_q   <= '0;
						first_q <= has_first;
						filt_q  <= has_median;
						tail_q  <= in_data.line_end_in;
						idx_q   <= has_first ? IW'(h_eff - HW_W'(1)) : IW'(pos_q);
						if (in_data.line_end_in)
							pos_q <= '0;
						else if (pos_q != POS_MAX)
							pos_q <= pos_q + LINE_POS_W'(1);
						if (has_median)
							state_q <= ST_COUNT;
						else if (has_first || in_data.line_end_in)
							state_q <= ST_EMIT;
					end
				end
				ST_COUNT: begin
					cnt_q <= cnt_q + IW'(1);
					if (count_done)
						state_q <= ST_PICK;
				end
				ST_PICK: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (load) begin
						if (first_q) begin
							first_q <= 1'b0;
							if (!tail_q)
								state_q <= ST_IDLE;
						end else if (idx_q == '0) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q <= idx_q - IW'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_PICK)
			med_q <= med_or;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (first_q) begin
				out_q.sample_out   <= filt_q ? med_q : rd_data;
				out_q.was_filtered <= filt_q;
				out_q.line_end_out <= 1'b0;
			end else begin
				out_q.sample_out   <= rd_data;
				out_q.was_filtered <= 1'b0;
				out_q.line_end_out <= (idx_q == '0);
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

### design/lmf_checker.sv
module lmf_checker
	import lmf_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                cfg_we,
	input logic [HW_CFG_W-1:0] cfg_wdata,
	input logic                in_valid,
	input logic                in_stall,
	input lmf_in_t             in_data,
	input logic                out_valid,
	input logic                out_stall,
	input lmf_out_t            out_data
);

	// a held result beat keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("output beat changed while stalled");

	// a median is never the closing beat of a line
	a_filt_not_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.was_filtered && out_data.line_end_out))
		else $error("filtered beat flagged as line end");

	// a line end always leaves results to hand out, so input stalls next
	a_end_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_data.line_end_in |=> in_stall)
		else $error("line end accepted without a flush");

	// right after reset the block is idle: no result is valid and input is not stalled
	a_reset_quiet: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid && !in_stall)
		else $error("block not idle after reset");

endmodule

bind line_median_filter lmf_checker u_lmf_checker (.*);
